/* design/gaps_pkg.sv */
package gaps_pkg;

    // default grid size
    localparam int GRID_W_DEF = 32;
    localparam int GRID_H_DEF = 32;

    // field widths of the item ports
    localparam int COORD_W = 5;
    localparam int INDEX_W = 10;
    localparam int LEN_W   = 11;

    // operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // per-cell search marks
    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_OPEN   = 2'd1;
    localparam logic [1:0] MARK_CLOSED = 2'd2;

    // neighbor directions, in expansion order
    localparam logic [1:0] DIR_PY = 2'd0;
    localparam logic [1:0] DIR_PX = 2'd1;
    localparam logic [1:0] DIR_NY = 2'd2;
    localparam logic [1:0] DIR_NX = 2'd3;

endpackage

/* design/grid_astar_path_search.sv */
// cell write goes through S_FIN to the output register; a path step read goes
//   through S_RD and S_FIN; search clears the node marks of every cell, then per
//   expansion runs the open list scan, the remove shift, and a read and evaluate
//   per neighbor; trace back writes and reads once per path cell
// one item at a time; the open list scan through the node memory sets search time
// reset (i_rst_n low, synchronous) clears control state, then a pass over all
//   GRID_W*GRID_H cells marks every cell blocked while o_in_stall stays high
module grid_astar_path_search import gaps_pkg::*; #(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [COORD_W-1:0] i_cell_x,
    input  logic [COORD_W-1:0] i_cell_y,
    input  logic               i_walkable,
    input  logic [COORD_W-1:0] i_target_x,
    input  logic [COORD_W-1:0] i_target_y,
    input  logic [INDEX_W-1:0] i_step_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_found,
    output logic [LEN_W-1:0]   o_path_length,
    output logic [COORD_W-1:0] o_step_x,
    output logic [COORD_W-1:0] o_step_y,
    output logic               o_step_valid
);

    localparam int NCELLS = GRID_W * GRID_H;
    localparam int AW     = $clog2(NCELLS);
    localparam int GW     = $clog2(NCELLS + 1);   // cost, list size, path length
    localparam int XW     = $clog2(GRID_W);
    localparam int YW     = $clog2(GRID_H);
    localparam int CDW    = XW + YW;              // packed {y, x}
    localparam int NW     = GW + 4;               // node word {mark, dir, cost}
    localparam int FW     = GW + 1;
    localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);

    // controller states
    localparam logic [3:0] S_WCLR  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_FIN   = 4'd3;
    localparam logic [3:0] S_NCLR  = 4'd4;
    localparam logic [3:0] S_INIT  = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_SHIFT = 4'd7;
    localparam logic [3:0] S_NB_RD = 4'd8;
    localparam logic [3:0] S_NB_EV = 4'd9;
    localparam logic [3:0] S_TR_WR = 4'd10;
    localparam logic [3:0] S_TR_RD = 4'd11;

    // cell coordinates to linear memory address
    function automatic logic [AW-1:0] addr_of(input logic [CDW-1:0] c);
        logic [AW-1:0] y;
        logic [AW-1:0] x;
        y = AW'(c[CDW-1:XW]);
        x = AW'(c[XW-1:0]);
        return AW'(y * AW'(GRID_W)) + x;
    endfunction

    // f = cost + manhattan distance to the goal
    function automatic logic [FW-1:0] f_of(input logic [CDW-1:0] c,
                                           input logic [CDW-1:0] t,
                                           input logic [GW-1:0] g);
        logic [XW-1:0] cx;
        logic [XW-1:0] tx;
        logic [YW-1:0] cy;
        logic [YW-1:0] ty;
        logic [XW-1:0] dx;
        logic [YW-1:0] dy;
        cx = c[XW-1:0];
        tx = t[XW-1:0];
        cy = c[CDW-1:XW];
        ty = t[CDW-1:XW];
        dx = (cx >= tx) ? cx - tx : tx - cx;
        dy = (cy >= ty) ? cy - ty : ty - cy;
        return FW'(g) + FW'(dx) + FW'(dy);
    endfunction

    // control and datapath registers
    logic [3:0]     r_state;
    logic [AW-1:0]  r_cnt;
    logic [1:0]     r_op;
    logic           r_sv;
    logic [AW-1:0]  r_ridx;
    logic [CDW-1:0] r_sc;
    logic [CDW-1:0] r_tc;
    logic [GW-1:0]  r_size;
    logic [GW-1:0]  r_si;
    logic           r_p1_v;
    logic [AW-1:0]  r_p1_i;
    logic           r_p2_v;
    logic [AW-1:0]  r_p2_i;
    logic [CDW-1:0] r_p2_c;
    logic [FW-1:0]  r_bf;
    logic [AW-1:0]  r_bi;
    logic [CDW-1:0] r_bc;
    logic [NW-1:0]  r_bn;
    logic [GW-1:0]  r_sh;
    logic           r_sh_v;
    logic [AW-1:0]  r_sh_a;
    logic [1:0]     r_d;
    logic [CDW-1:0] r_nc;
    logic [GW-1:0]  r_ti;
    logic [CDW-1:0] r_cur;
    logic           r_route_ok;
    logic [GW-1:0]  r_route_len;

    logic               r_out_valid;
    logic               r_found;
    logic [LEN_W-1:0]   r_len;
    logic [COORD_W-1:0] r_sx;
    logic [COORD_W-1:0] r_sy;
    logic               r_svo;

    // memory ports
    logic           walk_we;
    logic [AW-1:0]  walk_wa;
    logic           walk_wd;
    logic [AW-1:0]  walk_ra;
    logic           walk_q;
    logic           node_we;
    logic [AW-1:0]  node_wa;
    logic [NW-1:0]  node_wd;
    logic [AW-1:0]  node_ra;
    logic [NW-1:0]  node_q;
    logic           open_we;
    logic [AW-1:0]  open_wa;
    logic [CDW-1:0] open_wd;
    logic [AW-1:0]  open_ra;
    logic [CDW-1:0] open_q;
    logic           route_we;
    logic [AW-1:0]  route_wa;
    logic [CDW-1:0] route_wd;
    logic [CDW-1:0] route_q;

    // walkability bitmap
    gaps_ram #(.DW(1), .DEPTH(NCELLS), .AW(AW)) u_walk (
        .i_clk  (i_clk),
        .i_we   (walk_we),
        .i_waddr(walk_wa),
        .i_wdata(walk_wd),
        .i_raddr(walk_ra),
        .o_rdata(walk_q)
    );

    // per-cell mark, arrival direction and cost from start
    gaps_ram #(.DW(NW), .DEPTH(NCELLS), .AW(AW)) u_node (
        .i_clk  (i_clk),
        .i_we   (node_we),
        .i_waddr(node_wa),
        .i_wdata(node_wd),
        .i_raddr(node_ra),
        .o_rdata(node_q)
    );

    // open list in insertion order
    gaps_ram #(.DW(CDW), .DEPTH(NCELLS), .AW(AW)) u_open (
        .i_clk  (i_clk),
        .i_we   (open_we),
        .i_waddr(open_wa),
        .i_wdata(open_wd),
        .i_raddr(open_ra),
        .o_rdata(open_q)
    );

    // stored path, start first
    gaps_ram #(.DW(CDW), .DEPTH(NCELLS), .AW(AW)) u_route (
        .i_clk  (i_clk),
        .i_we   (route_we),
        .i_waddr(route_wa),
        .i_wdata(route_wd),
        .i_raddr(r_ridx),
        .o_rdata(route_q)
    );

    // input decode
    logic           in_take;
    logic           cell_in;
    logic           tgt_in;
    logic [CDW-1:0] in_c;
    logic [CDW-1:0] in_t;

    assign in_take = i_in_valid && (r_state == S_IDLE);
    assign cell_in = (32'(i_cell_x) < GRID_W) && (32'(i_cell_y) < GRID_H);
    assign tgt_in  = (32'(i_target_x) < GRID_W) && (32'(i_target_y) < GRID_H);
    assign in_c    = {YW'(i_cell_y), XW'(i_cell_x)};
    assign in_t    = {YW'(i_target_y), XW'(i_target_x)};

    // scan stage two: f of the entry whose node word just came back
    logic [GW-1:0] p2_g;
    logic [FW-1:0] p2_f;
    logic          p2_better;
    logic          scan_done;

    assign p2_g      = node_q[GW-1:0];
    assign p2_f      = f_of(r_p2_c, r_tc, p2_g);
    assign p2_better = r_p2_v && ((r_p2_i == '0) || (p2_f < r_bf));
    assign scan_done = (r_si == r_size) && !r_p1_v && !r_p2_v;

    // current expansion
    logic [XW-1:0] bx;
    logic [YW-1:0] by;
    logic [GW-1:0] bg;
    logic [GW-1:0] tg;

    assign bx = r_bc[XW-1:0];
    assign by = r_bc[CDW-1:XW];
    assign bg = r_bn[GW-1:0];
    assign tg = bg + GW'(1);

    // neighbor in direction r_d, with grid bounds check
    logic           nb_ok;
    logic [CDW-1:0] nb_c;

    always_comb begin
        nb_ok = 1'b0;
        nb_c  = r_bc;
        unique case (r_d)
            DIR_PY: begin
                nb_ok = (32'(by) + 1 < GRID_H);
                nb_c  = {by + YW'(1), bx};
            end
            DIR_PX: begin
                nb_ok = (32'(bx) + 1 < GRID_W);
                nb_c  = {by, bx + XW'(1)};
            end
            DIR_NY: begin
                nb_ok = (by != '0);
                nb_c  = {by - YW'(1), bx};
            end
            DIR_NX: begin
                nb_ok = (bx != '0);
                nb_c  = {by, bx - XW'(1)};
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // neighbor relaxation
    logic [1:0]    nb_mark;
    logic [GW-1:0] nb_g;
    logic          nb_upd;
    logic          nb_app;

    assign nb_mark = node_q[NW-1:NW-2];
    assign nb_g    = node_q[GW-1:0];
    assign nb_upd  = walk_q && (nb_mark != MARK_CLOSED)
                     && ((nb_mark != MARK_OPEN) || (tg < nb_g));
    assign nb_app  = nb_upd && (nb_mark != MARK_OPEN);

    // trace back: step against the stored arrival direction
    logic [XW-1:0]  cx;
    logic [YW-1:0]  cy;
    logic           pr_ok;
    logic [CDW-1:0] pr_c;

    assign cx = r_cur[XW-1:0];
    assign cy = r_cur[CDW-1:XW];

    always_comb begin
        pr_ok = 1'b0;
        pr_c  = r_cur;
        unique case (node_q[NW-3:NW-4])
            DIR_PY: begin
                pr_ok = (cy != '0);
                pr_c  = {cy - YW'(1), cx};
            end
            DIR_PX: begin
                pr_ok = (cx != '0);
                pr_c  = {cy, cx - XW'(1)};
            end
            DIR_NY: begin
                pr_ok = (32'(cy) + 1 < GRID_H);
                pr_c  = {cy + YW'(1), cx};
            end
            DIR_NX: begin
                pr_ok = (32'(cx) + 1 < GRID_W);
                pr_c  = {cy, cx + XW'(1)};
            end
            default: begin
                pr_ok = 1'b0;
            end
        endcase
    end

    logic trace_end;
    assign trace_end = (r_cur == r_sc) || (r_ti == GW'(1));

    // memory port selection
    always_comb begin
        walk_we  = 1'b0;
        walk_wa  = r_cnt;
        walk_wd  = 1'b0;
        walk_ra  = addr_of(nb_c);
        node_we  = 1'b0;
        node_wa  = r_cnt;
        node_wd  = '0;
        node_ra  = addr_of(nb_c);
        open_we  = 1'b0;
        open_wa  = r_size[AW-1:0];
        open_wd  = r_nc;
        open_ra  = r_si[AW-1:0];
        route_we = 1'b0;
        route_wa = AW'(r_ti - GW'(1));
        route_wd = r_cur;
        case (r_state)
            S_WCLR: begin
                walk_we = 1'b1;
            end
            S_IDLE: begin
                walk_we = in_take && (i_op == OP_WRITE) && cell_in;
                walk_wa = addr_of(in_c);
                walk_wd = i_walkable;
            end
            S_NCLR: begin
                node_we = 1'b1;
            end
            S_INIT: begin
                // start enters the open list even when blocked
                node_we = 1'b1;
                node_wa = addr_of(r_sc);
                node_wd = {MARK_OPEN, 2'b00, GW'(0)};
                open_we = 1'b1;
                open_wa = '0;
                open_wd = r_sc;
            end
            S_SCAN: begin
                node_ra = addr_of(open_q);
                // close the chosen cell unless it is the goal
                node_we = scan_done && (r_bc != r_tc);
                node_wa = addr_of(r_bc);
                node_wd = {MARK_CLOSED, r_bn[NW-3:0]};
            end
            S_SHIFT: begin
                open_ra = r_sh[AW-1:0];
                open_we = r_sh_v;
                open_wa = r_sh_a;
                open_wd = open_q;
            end
            S_NB_EV: begin
                node_we = nb_upd;
                node_wa = addr_of(r_nc);
                node_wd = {MARK_OPEN, r_d, tg};
                open_we = nb_app;
            end
            S_TR_WR: begin
                route_we = 1'b1;
                node_ra  = addr_of(r_cur);
            end
            default: begin
            end
        endcase
    end

    // controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WCLR;
            r_cnt       <= '0;
            r_size      <= '0;
            r_si        <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_sh_v      <= 1'b0;
            r_route_ok  <= 1'b0;
            r_route_len <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_WCLR: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == LAST_CELL) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_take) begin
                        r_op <= i_op;
                        unique case (i_op)
                            OP_SEARCH: begin
                                r_route_ok  <= 1'b0;
                                r_route_len <= '0;
                                r_size      <= '0;
                                r_sc        <= in_c;
                                r_tc        <= in_t;
                                r_cnt       <= '0;
                                r_state     <= (cell_in && tgt_in) ? S_NCLR : S_FIN;
                            end
                            OP_READ: begin
                                r_sv    <= (32'(i_step_index) < 32'(r_route_len))
                                           && (32'(i_step_index) < NCELLS);
                                r_ridx  <= AW'(i_step_index);
                                r_state <= S_RD;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_found     <= r_route_ok;
                        r_len       <= LEN_W'(r_route_len);
                        r_svo       <= (r_op == OP_READ) && r_sv;
                        r_sx        <= ((r_op == OP_READ) && r_sv)
                                       ? COORD_W'(route_q[XW-1:0]) : '0;
                        r_sy        <= ((r_op == OP_READ) && r_sv)
                                       ? COORD_W'(route_q[CDW-1:XW]) : '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_NCLR: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == LAST_CELL) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_size  <= GW'(1);
                    r_si    <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // stage one: open list entry, stage two: its node word
                    if (r_si < r_size) begin
                        r_si   <= r_si + GW'(1);
                        r_p1_v <= 1'b1;
                        r_p1_i <= r_si[AW-1:0];
                    end else begin
                        r_p1_v <= 1'b0;
                    end
                    r_p2_v <= r_p1_v;
                    r_p2_i <= r_p1_i;
                    r_p2_c <= open_q;
                    if (p2_better) begin
                        r_bf <= p2_f;
                        r_bi <= r_p2_i;
                        r_bc <= r_p2_c;
                        r_bn <= node_q;
                    end
                    if (scan_done) begin
                        if (r_bc == r_tc) begin
                            r_route_len <= tg;
                            r_ti        <= tg;
                            r_cur       <= r_bc;
                            r_state     <= S_TR_WR;
                        end else begin
                            r_sh    <= GW'(r_bi) + GW'(1);
                            r_sh_v  <= 1'b0;
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    // close the gap left by the removed entry
                    if (r_sh < r_size) begin
                        r_sh_v <= 1'b1;
                        r_sh_a <= r_sh[AW-1:0] - AW'(1);
                        r_sh   <= r_sh + GW'(1);
                    end else begin
                        r_sh_v <= 1'b0;
                        if (!r_sh_v) begin
                            r_size  <= r_size - GW'(1);
                            r_d     <= DIR_PY;
                            r_state <= S_NB_RD;
                        end
                    end
                end
                S_NB_RD: begin
                    if (nb_ok) begin
                        r_nc    <= nb_c;
                        r_state <= S_NB_EV;
                    end else if (r_d == DIR_NX) begin
                        r_si    <= '0;
                        r_state <= (r_size != '0) ? S_SCAN : S_FIN;
                    end else begin
                        r_d <= r_d + 2'd1;
                    end
                end
                S_NB_EV: begin
                    if (nb_app) begin
                        r_size <= r_size + GW'(1);
                    end
                    if (r_d == DIR_NX) begin
                        r_si    <= '0;
                        r_state <= ((r_size != '0) || nb_app) ? S_SCAN : S_FIN;
                    end else begin
                        r_d     <= r_d + 2'd1;
                        r_state <= S_NB_RD;
                    end
                end
                S_TR_WR: begin
                    if (trace_end) begin
                        r_route_ok <= 1'b1;
                        r_state    <= S_FIN;
                    end else begin
                        r_state <= S_TR_RD;
                    end
                end
                S_TR_RD: begin
                    if (pr_ok) begin
                        r_cur   <= pr_c;
                        r_ti    <= r_ti - GW'(1);
                        r_state <= S_TR_WR;
                    end else begin
                        r_route_ok <= 1'b1;
                        r_state    <= S_FIN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_path_length = r_len;
    assign o_step_x      = r_sx;
    assign o_step_y      = r_sy;
    assign o_step_valid  = r_svo;

    // a stored path always holds at least the start cell
    a_ok_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_route_ok |-> (r_route_len != '0))
        else $error("route marked found with zero length");

    // the open list never holds more entries than the grid has cells
    a_size : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_size) <= NCELLS)
        else $error("open list overflow");

    // trace back never writes below path index zero
    a_trace : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TR_WR) |-> (r_ti != '0))
        else $error("trace back index underflow");

    // scan stage two only follows a stage one read
    a_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_p2_v |-> $past(r_p1_v))
        else $error("scan pipeline out of step");

endmodule

/* design/gaps_ram.sv */
module gaps_ram import gaps_pkg::*; #(
    parameter int DW    = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
